// ----- rtl/mmriw_pkg.sv -----
// ----------------------------------------------------------------------------
// mmriw_pkg
// Shared types, constants and the control store of the masked odometer walker.
// ----------------------------------------------------------------------------
package mmriw_pkg;

  // Walk geometry
  localparam int MAX_DIM      = 16;
  localparam int PLAYER_COUNT = 2;
  localparam int NUM_DIGITS   = 1 + 2 * PLAYER_COUNT;
  localparam int DIGIT_W      = 4;
  localparam int SIZE_W       = 5;
  localparam int PTR_W        = $clog2(NUM_DIGITS);
  localparam int INDEX_W      = 20;
  localparam int ST_INDEX_W   = 12;

  // Largest usable digit range
  localparam logic [SIZE_W-1:0] DIM_CAP = SIZE_W'((MAX_DIM < 16) ? MAX_DIM : 16);

  // Register map (word index on the configuration port)
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_DIM_SIZES  = 3'd0;
  localparam logic [2:0] REG_STATE_SEL  = 3'd1;
  localparam logic [2:0] REG_ACTION_SEL = 3'd2;
  localparam logic [2:0] REG_TYPE_SEL   = 3'd3;
  localparam logic [2:0] REG_MARG_SEL   = 3'd4;

  typedef logic [DIGIT_W-1:0]                   digit_t;
  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0]   digit_vec_t;
  typedef logic [NUM_DIGITS-1:0][SIZE_W-1:0]    size_vec_t;

  // Walk status from the digit unit to the sequencer
  typedef struct packed {
    size_vec_t  sizes;
    digit_vec_t first;
    digit_vec_t advanced;
    logic       has_succ;
  } walk_info_t;

  // Micro-operations
  localparam logic [2:0] OP_FIRST   = 3'd0;
  localparam logic [2:0] OP_CLEAR   = 3'd1;
  localparam logic [2:0] OP_MAC     = 3'd2;
  localparam logic [2:0] OP_TEST    = 3'd3;
  localparam logic [2:0] OP_ADVANCE = 3'd4;
  localparam logic [2:0] OP_FINISH  = 3'd5;

  // Jump conditions
  localparam logic [1:0] JMP_NEVER  = 2'd0;
  localparam logic [1:0] JMP_ALWAYS = 2'd1;
  localparam logic [1:0] JMP_MORE   = 2'd2;
  localparam logic [1:0] JMP_DONE   = 2'd3;

  // Program addresses
  localparam logic [2:0] STEP_RESTART = 3'd0;
  localparam logic [2:0] STEP_SEEK    = 3'd1;
  localparam logic [2:0] STEP_MAC     = 3'd2;
  localparam logic [2:0] STEP_TEST    = 3'd3;
  localparam logic [2:0] STEP_ADVANCE = 3'd4;
  localparam logic [2:0] STEP_FINISH  = 3'd5;

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] cond;
    logic [2:0] target;
  } uword_t;

  // Control store
  function automatic uword_t ucode(input logic [2:0] addr);
    uword_t w;
    case (addr)
      STEP_RESTART: w = '{op: OP_FIRST,   cond: JMP_NEVER,  target: STEP_SEEK};
      STEP_SEEK:    w = '{op: OP_CLEAR,   cond: JMP_NEVER,  target: STEP_MAC};
      STEP_MAC:     w = '{op: OP_MAC,     cond: JMP_MORE,   target: STEP_MAC};
      STEP_TEST:    w = '{op: OP_TEST,    cond: JMP_DONE,   target: STEP_FINISH};
      STEP_ADVANCE: w = '{op: OP_ADVANCE, cond: JMP_ALWAYS, target: STEP_SEEK};
      default:      w = '{op: OP_FINISH,  cond: JMP_NEVER,  target: STEP_FINISH};
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/mmriw_if.sv -----
// ----------------------------------------------------------------------------
// mmriw channel interfaces
// Command and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mmriw_cmd_if;
  logic                               valid;
  logic                               ready;
  logic                               func;
  logic [mmriw_pkg::INDEX_W-1:0]      target_index;

  modport source (output valid, func, target_index, input ready);
  modport sink   (input valid, func, target_index, output ready);
endinterface

interface mmriw_rsp_if;
  logic                               valid;
  logic                               ready;
  logic                               matched;
  logic                               exhausted;
  logic [mmriw_pkg::INDEX_W-1:0]      full_index;
  logic [mmriw_pkg::INDEX_W-1:0]      marginal_index;
  logic [mmriw_pkg::ST_INDEX_W-1:0]   state_type_index;
  logic [mmriw_pkg::DIGIT_W-1:0]      state_value;
  logic [mmriw_pkg::DIGIT_W-1:0]      action_zero;
  logic [mmriw_pkg::DIGIT_W-1:0]      action_one;
  logic [mmriw_pkg::DIGIT_W-1:0]      type_zero;
  logic [mmriw_pkg::DIGIT_W-1:0]      type_one;

  modport source (output valid, matched, exhausted, full_index, marginal_index,
                  state_type_index, state_value, action_zero, action_one,
                  type_zero, type_one, input ready);
  modport sink   (input valid, matched, exhausted, full_index, marginal_index,
                  state_type_index, state_value, action_zero, action_one,
                  type_zero, type_one, output ready);
endinterface

// ----- rtl/mmriw_digit_unit.sv -----
// ----------------------------------------------------------------------------
// mmriw_digit_unit
// Per-digit sizes and masks, first allowed values, and the odometer step.
// ----------------------------------------------------------------------------
module mmriw_digit_unit (
  input  mmriw_pkg::digit_vec_t                        digits,
  input  logic [mmriw_pkg::NUM_DIGITS*mmriw_pkg::SIZE_W-1:0] dimension_sizes,
  input  logic [15:0]                                  state_select,
  input  logic [31:0]                                  action_select,
  input  logic [31:0]                                  type_select,
  output mmriw_pkg::walk_info_t                        info
);

  logic [mmriw_pkg::NUM_DIGITS-1:0][15:0] raw_sel;

  // Route each select mask to its digit
  assign raw_sel[0] = state_select;
  assign raw_sel[1] = action_select[15:0];
  assign raw_sel[2] = action_select[31:16];
  assign raw_sel[3] = type_select[15:0];
  assign raw_sel[4] = type_select[31:16];

  always_comb begin
    logic [mmriw_pkg::SIZE_W-1:0]  fld;
    logic [mmriw_pkg::SIZE_W-1:0]  size;
    logic [15:0]                   lim;
    logic [15:0]                   msk;
    logic [15:0]                   above;
    mmriw_pkg::digit_t             first_v;
    mmriw_pkg::digit_t             next_v;
    logic                          carry;
    info  = '0;
    carry = 1'b1;
    for (int i = 0; i < mmriw_pkg::NUM_DIGITS; i++) begin
      // Clamp the size into 1..cap
      fld = dimension_sizes[mmriw_pkg::SIZE_W*i +: mmriw_pkg::SIZE_W];
      if (fld == '0) begin
        size = mmriw_pkg::SIZE_W'(1);
      end else if (fld > mmriw_pkg::DIM_CAP) begin
        size = mmriw_pkg::DIM_CAP;
      end else begin
        size = fld;
      end
      info.sizes[i] = size;

      // Restrict the mask to the size; empty means all
      lim = 16'((17'd1 << size) - 17'd1);
      msk = raw_sel[i] & lim;
      if (msk == '0) begin
        msk = lim;
      end

      // Lowest allowed value, and lowest allowed value above the digit
      above   = msk & (16'hFFFE << digits[i]);
      first_v = '0;
      next_v  = '0;
      for (int v = 15; v >= 0; v--) begin
        if (msk[v]) begin
          first_v = mmriw_pkg::DIGIT_W'(v);
        end
        if (above[v]) begin
          next_v = mmriw_pkg::DIGIT_W'(v);
        end
      end
      info.first[i] = first_v;

      // Odometer carry: lower digits wrap, first digit with room steps
      if (carry && (above != '0)) begin
        info.advanced[i] = next_v;
        carry            = 1'b0;
      end else if (carry) begin
        info.advanced[i] = first_v;
      end else begin
        info.advanced[i] = digits[i];
      end
      if (above != '0) begin
        info.has_succ = 1'b1;
      end
    end
  end

endmodule

// ----- rtl/masked_mixed_radix_index_walker_unit.sv -----
// ----------------------------------------------------------------------------
// masked_mixed_radix_index_walker_unit
// Masked five-digit odometer with full, marginal and state-type indices.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one word per request: func 0 restarts the walker at the first
//   allowed combination, func 1 seeks forward until the full index reaches
//   target_index or the walk runs out. rsp returns one word per request with
//   the match and exhausted flags, the three indices and the five digits.
//   Registers are written over the APB port while the block is idle; the
//   user must keep to this, as the block itself has no check for it.
// Sequencing:
//   A small microprogram drives the three index multiply-accumulates, one
//   digit per cycle. One index pass clears the accumulators, takes the five
//   digits and tests the result; a seek adds an odometer step between
//   passes. One request is in work at a time; cmd is ready whenever the
//   sequencer is idle, also while a finished word still waits in the rsp
//   register.
// Reset and stall:
//   Reset clears the digits, the registers (marginal select to all ones) and
//   both handshakes. A stalled rsp holds its word; a following request then
//   waits at its finish step until the rsp register is free.
// ----------------------------------------------------------------------------
module masked_mixed_radix_index_walker_unit (
  input  logic                            clk,
  input  logic                            rst,
  mmriw_cmd_if.sink                       cmd,
  mmriw_rsp_if.source                     rsp,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mmriw_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int NSW = mmriw_pkg::NUM_DIGITS * mmriw_pkg::SIZE_W;
  localparam int IW  = mmriw_pkg::INDEX_W;
  localparam int SW  = mmriw_pkg::ST_INDEX_W;

  // Configuration registers
  logic [NSW-1:0]                  dimension_sizes;
  logic [15:0]                     state_select;
  logic [31:0]                     action_select;
  logic [31:0]                     type_select;
  logic [mmriw_pkg::NUM_DIGITS-1:0] marginal_select;

  // Sequencer and datapath
  logic                            busy;
  logic [2:0]                      step;
  logic [2:0]                      step_next;
  logic                            seek;
  logic [IW-1:0]                   target;
  logic [mmriw_pkg::PTR_W-1:0]     ptr;
  logic [IW-1:0]                   full_acc;
  logic [IW-1:0]                   marg_acc;
  logic [SW-1:0]                   st_acc;
  mmriw_pkg::digit_vec_t           digits;
  mmriw_pkg::walk_info_t           info;
  mmriw_pkg::uword_t               ctrl;
  logic                            jump;
  logic                            out_free;
  logic                            wr_en;

  // Response register
  logic                            rsp_valid;
  logic                            rsp_matched;
  logic                            rsp_exhausted;
  logic [IW-1:0]                   rsp_full;
  logic [IW-1:0]                   rsp_marg;
  logic [SW-1:0]                   rsp_st;
  mmriw_pkg::digit_vec_t           rsp_digits;

  // MAC operands
  mmriw_pkg::digit_t               mac_d;
  logic [mmriw_pkg::SIZE_W-1:0]    mac_s;
  logic [IW+mmriw_pkg::SIZE_W-1:0] full_mac;
  logic [IW+mmriw_pkg::SIZE_W-1:0] marg_mac;
  logic [SW+mmriw_pkg::SIZE_W-1:0] st_mac;
  logic                            st_take;

  mmriw_digit_unit u_digit (
    .digits          (digits),
    .dimension_sizes (dimension_sizes),
    .state_select    (state_select),
    .action_select   (action_select),
    .type_select     (type_select),
    .info            (info)
  );

  // APB access
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    case (paddr[4:2])
      mmriw_pkg::REG_DIM_SIZES:  prdata = 32'(dimension_sizes);
      mmriw_pkg::REG_STATE_SEL:  prdata = 32'(state_select);
      mmriw_pkg::REG_ACTION_SEL: prdata = action_select;
      mmriw_pkg::REG_TYPE_SEL:   prdata = type_select;
      mmriw_pkg::REG_MARG_SEL:   prdata = 32'(marginal_select);
      default:                   prdata = '0;
    endcase
  end

  // Fetch the control word
  assign ctrl     = mmriw_pkg::ucode(step);
  assign out_free = !rsp_valid || rsp.ready;

  // Resolve the jump condition
  always_comb begin
    case (ctrl.cond)
      mmriw_pkg::JMP_ALWAYS: jump = 1'b1;
      mmriw_pkg::JMP_MORE:   jump = (ptr != '0);
      mmriw_pkg::JMP_DONE:   jump = !seek || (full_acc >= target) || !info.has_succ;
      default:               jump = 1'b0;
    endcase
    step_next = jump ? ctrl.target : step + 3'd1;
  end

  // One digit of the index accumulation
  assign mac_d    = digits[ptr];
  assign mac_s    = info.sizes[ptr];
  assign full_mac = (IW+mmriw_pkg::SIZE_W)'(full_acc) * (IW+mmriw_pkg::SIZE_W)'(mac_s)
                    + (IW+mmriw_pkg::SIZE_W)'(mac_d);
  assign marg_mac = (IW+mmriw_pkg::SIZE_W)'(marg_acc) * (IW+mmriw_pkg::SIZE_W)'(mac_s)
                    + (IW+mmriw_pkg::SIZE_W)'(mac_d);
  assign st_mac   = (SW+mmriw_pkg::SIZE_W)'(st_acc) * (SW+mmriw_pkg::SIZE_W)'(mac_s)
                    + (SW+mmriw_pkg::SIZE_W)'(mac_d);
  assign st_take  = (ptr == '0) || (ptr > mmriw_pkg::PTR_W'(mmriw_pkg::PLAYER_COUNT));

  // Control state, configuration and digits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy            <= 1'b0;
      step            <= mmriw_pkg::STEP_RESTART;
      rsp_valid       <= 1'b0;
      digits          <= '0;
      dimension_sizes <= '0;
      state_select    <= '0;
      action_select   <= '0;
      type_select     <= '0;
      marginal_select <= '1;
    end else begin
      // Register writes
      if (wr_en) begin
        case (paddr[4:2])
          mmriw_pkg::REG_DIM_SIZES:  dimension_sizes <= pwdata[NSW-1:0];
          mmriw_pkg::REG_STATE_SEL:  state_select    <= pwdata[15:0];
          mmriw_pkg::REG_ACTION_SEL: action_select   <= pwdata;
          mmriw_pkg::REG_TYPE_SEL:   type_select     <= pwdata;
          mmriw_pkg::REG_MARG_SEL:   marginal_select <= pwdata[mmriw_pkg::NUM_DIGITS-1:0];
          default: ;
        endcase
      end

      // Load a finished word, drop a delivered one
      if (busy && (ctrl.op == mmriw_pkg::OP_FINISH) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      if (!busy) begin
        // Take a new request
        if (cmd.valid) begin
          busy <= 1'b1;
          step <= cmd.func ? mmriw_pkg::STEP_SEEK : mmriw_pkg::STEP_RESTART;
        end
      end else begin
        case (ctrl.op)
          mmriw_pkg::OP_FIRST:   digits <= info.first;
          mmriw_pkg::OP_ADVANCE: digits <= info.advanced;
          mmriw_pkg::OP_FINISH: begin
            if (out_free) begin
              busy <= 1'b0;
            end
          end
          default: ;
        endcase
        // Advance the program, hold at finish
        if (ctrl.op != mmriw_pkg::OP_FINISH) begin
          step <= step_next;
        end
      end
    end
  end

  // Datapath payload
  always_ff @(posedge clk) begin
    if (!busy && cmd.valid) begin
      seek   <= cmd.func;
      target <= cmd.target_index;
    end
    if (busy) begin
      case (ctrl.op)
        mmriw_pkg::OP_CLEAR: begin
          full_acc <= '0;
          marg_acc <= '0;
          st_acc   <= '0;
          ptr      <= mmriw_pkg::PTR_W'(mmriw_pkg::NUM_DIGITS - 1);
        end
        mmriw_pkg::OP_MAC: begin
          full_acc <= full_mac[IW-1:0];
          if (marginal_select[ptr]) begin
            marg_acc <= marg_mac[IW-1:0];
          end
          if (st_take) begin
            st_acc <= st_mac[SW-1:0];
          end
          ptr <= ptr - mmriw_pkg::PTR_W'(1);
        end
        mmriw_pkg::OP_FINISH: begin
          if (out_free) begin
            rsp_matched   <= seek && (full_acc == target);
            rsp_exhausted <= !info.has_succ;
            rsp_full      <= full_acc;
            rsp_marg      <= marg_acc;
            rsp_st        <= st_acc;
            rsp_digits    <= digits;
          end
        end
        default: ;
      endcase
    end
  end

  // Channel outputs
  assign cmd.ready            = !busy;
  assign rsp.valid            = rsp_valid;
  assign rsp.matched          = rsp_matched;
  assign rsp.exhausted        = rsp_exhausted;
  assign rsp.full_index       = rsp_full;
  assign rsp.marginal_index   = rsp_marg;
  assign rsp.state_type_index = rsp_st;
  assign rsp.state_value      = rsp_digits[0];
  assign rsp.action_zero      = rsp_digits[1];
  assign rsp.action_one       = rsp_digits[2];
  assign rsp.type_zero        = rsp_digits[3];
  assign rsp.type_one         = rsp_digits[4];

`ifndef NO_ASSERTIONS
  // An odometer step only runs when a successor exists
  a_adv_has_succ: assert property (@(posedge clk) disable iff (rst)
    (busy && (ctrl.op == mmriw_pkg::OP_ADVANCE)) |-> info.has_succ)
    else $error("advance issued with no successor");

  // An accepted request starts the sequencer
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> busy)
    else $error("sequencer idle after accept");

  // A response appears only out of the finish step
  a_rsp_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(busy && (ctrl.op == mmriw_pkg::OP_FINISH)))
    else $error("response raised outside finish step");
`endif

endmodule

// ----- tb/mmriw_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// mmriw_tb_pkg
// Request codes and the response word layout shared by the bench and checker.
// ----------------------------------------------------------------------------
package mmriw_tb_pkg;

  import mmriw_pkg::*;

  // Request codes carried on cmd.func
  localparam logic FN_RESTART = 1'b0;
  localparam logic FN_SEEK    = 1'b1;

  // One response word as it appears on the rsp channel
  typedef struct packed {
    logic                  matched;
    logic                  exhausted;
    logic [INDEX_W-1:0]    full_index;
    logic [INDEX_W-1:0]    marginal_index;
    logic [ST_INDEX_W-1:0] state_type_index;
    digit_t                state_value;
    digit_t                action_zero;
    digit_t                action_one;
    digit_t                type_zero;
    digit_t                type_one;
  } walk_word_t;

endpackage

// ----- tb/mmriw_walk_checker.sv -----
// ----------------------------------------------------------------------------
// mmriw_walk_checker
// Passive checker: tracks register writes, models the masked odometer walk
// for every accepted request and compares each response word field by field.
// ----------------------------------------------------------------------------
module mmriw_walk_checker
  import mmriw_pkg::*;
  import mmriw_tb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  mmriw_cmd_if              cmd,
  mmriw_rsp_if              rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                fail_count,
  output int                pending
);

  // Digit positions, fastest first
  localparam int D_STATE = 0;
  localparam int D_ACT0  = 1;
  localparam int D_ACT1  = 2;
  localparam int D_TYPE0 = 3;
  localparam int D_TYPE1 = 4;

  localparam int DIGIT_SPAN = 1 << DIGIT_W;

  // Shadow registers and walker digits
  logic [NUM_DIGITS*SIZE_W-1:0] size_reg;
  logic [15:0]                  state_mask_reg;
  logic [31:0]                  action_mask_reg;
  logic [31:0]                  type_mask_reg;
  logic [NUM_DIGITS-1:0]        marg_reg;
  digit_t                       odo [NUM_DIGITS];

  walk_word_t predicted_words [$];

  // Effective radix of a digit: zero counts as one, large sizes clamp
  function automatic int radix(input int i);
    int f;
    f = int'(size_reg[SIZE_W*i +: SIZE_W]);
    if (f == 0) f = 1;
    if (f > int'(DIM_CAP)) f = int'(DIM_CAP);
    return f;
  endfunction

  // Allowed values of a digit; an empty mask allows the whole range
  function automatic logic [15:0] allowed_set(input int i);
    logic [15:0] raw;
    logic [15:0] lim;
    case (i)
      D_STATE: raw = state_mask_reg;
      D_ACT0:  raw = action_mask_reg[15:0];
      D_ACT1:  raw = action_mask_reg[31:16];
      D_TYPE0: raw = type_mask_reg[15:0];
      default: raw = type_mask_reg[31:16];
    endcase
    lim = 16'((32'd1 << radix(i)) - 1);
    raw &= lim;
    return (raw != 16'h0) ? raw : lim;
  endfunction

  // Next allowed value above d, DIGIT_SPAN when there is none
  function automatic int next_above(input int i, input int d);
    logic [15:0] m;
    int v;
    m = allowed_set(i);
    for (v = d + 1; v < DIGIT_SPAN; v++) begin
      if (m[v]) return v;
    end
    return DIGIT_SPAN;
  endfunction

  // Advance the odometer by one allowed combination
  function automatic bit step_odometer();
    int i;
    int j;
    int n;
    for (i = 0; i < NUM_DIGITS; i++) begin
      n = next_above(i, int'(odo[i]));
      if (n < DIGIT_SPAN) begin
        odo[i] = digit_t'(n);
        for (j = 0; j < i; j++) odo[j] = digit_t'(next_above(j, -1));
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit walk_can_advance();
    int i;
    for (i = 0; i < NUM_DIGITS; i++) begin
      if (next_above(i, int'(odo[i])) < DIGIT_SPAN) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Build the indices and digits of the current combination
  function automatic walk_word_t index_word();
    walk_word_t w;
    int f;
    int m;
    int st;
    int s;
    int i;
    f  = 0;
    m  = 0;
    st = 0;
    for (i = NUM_DIGITS - 1; i >= 0; i--) begin
      s = radix(i);
      f = f * s + int'(odo[i]);
      if (marg_reg[i]) m = m * s + int'(odo[i]);
      if (i == D_STATE || i > PLAYER_COUNT) st = st * s + int'(odo[i]);
    end
    w                  = '0;
    w.full_index       = f[INDEX_W-1:0];
    w.marginal_index   = m[INDEX_W-1:0];
    w.state_type_index = st[ST_INDEX_W-1:0];
    w.state_value      = odo[D_STATE];
    w.action_zero      = odo[D_ACT0];
    w.action_one       = odo[D_ACT1];
    w.type_zero        = odo[D_TYPE0];
    w.type_one         = odo[D_TYPE1];
    return w;
  endfunction

  // Apply one request to the walker and return the word it should produce
  function automatic walk_word_t predict_walk(input logic fn, input logic [INDEX_W-1:0] tgt);
    walk_word_t w;
    int i;
    if (fn == FN_RESTART) begin
      for (i = 0; i < NUM_DIGITS; i++) odo[i] = digit_t'(next_above(i, -1));
      w = index_word();
    end else begin
      w = index_word();
      while (w.full_index < tgt) begin
        if (!step_odometer()) break;
        w = index_word();
      end
      w.matched = (w.full_index == tgt);
    end
    w.exhausted = !walk_can_advance();
    return w;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Track register writes, retire response words, queue predictions
  always @(posedge clk) begin
    walk_word_t want;
    if (rst) begin
      fail_count      = 0;
      size_reg        = '0;
      state_mask_reg  = '0;
      action_mask_reg = '0;
      type_mask_reg   = '0;
      marg_reg        = '1;
      for (int i = 0; i < NUM_DIGITS; i++) odo[i] = '0;
      predicted_words.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_DIM_SIZES:  size_reg        = pwdata[NUM_DIGITS*SIZE_W-1:0];
          REG_STATE_SEL:  state_mask_reg  = pwdata[15:0];
          REG_ACTION_SEL: action_mask_reg = pwdata;
          REG_TYPE_SEL:   type_mask_reg   = pwdata;
          REG_MARG_SEL:   marg_reg        = pwdata[NUM_DIGITS-1:0];
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        if (predicted_words.size() == 0) begin
          $display("%0t: response word with no request outstanding", $time);
          fail_count++;
        end else begin
          want = predicted_words.pop_front();
          check_field("matched", want.matched, rsp.matched);
          check_field("exhausted", want.exhausted, rsp.exhausted);
          check_field("full_index", want.full_index, rsp.full_index);
          check_field("marginal_index", want.marginal_index, rsp.marginal_index);
          check_field("state_type_index", want.state_type_index, rsp.state_type_index);
          check_field("state_value", want.state_value, rsp.state_value);
          check_field("action_zero", want.action_zero, rsp.action_zero);
          check_field("action_one", want.action_one, rsp.action_one);
          check_field("type_zero", want.type_zero, rsp.type_zero);
          check_field("type_one", want.type_one, rsp.type_one);
        end
      end
      // Queue the expected word behind the ones still outstanding
      if (cmd.valid && cmd.ready) begin
        predicted_words.insert(predicted_words.size(),
                               predict_walk(cmd.func, cmd.target_index));
      end
    end
    pending = predicted_words.size();
  end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives restart and seek requests and register setups into the odometer
// walker under random idling and back-pressure; the checker judges each word.
// ----------------------------------------------------------------------------
module tb_top;

  import mmriw_pkg::*;
  import mmriw_tb_pkg::*;

  localparam int IDLE_LIMIT    = 60000;
  localparam int LONG_HOLD     = 300;
  localparam int RANDOM_PHASES = 22;
  localparam int PHASE_ITEMS   = 52;
  localparam int MAX_COMBOS    = 1024;

  localparam logic [NUM_DIGITS*SIZE_W-1:0] SIZES_ALL_16 = {NUM_DIGITS{5'd16}};
  localparam logic [NUM_DIGITS*SIZE_W-1:0] SIZES_ALL_2  = {NUM_DIGITS{5'd2}};

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  int fails;
  int pending;
  int idle_cycles = 0;
  int gap_max;
  int stall_max;
  bit hold_rsp;

  mmriw_cmd_if cmd_if ();
  mmriw_rsp_if rsp_if ();

  masked_mixed_radix_index_walker_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_if),
    .rsp     (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  mmriw_walk_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_if),
    .rsp        (rsp_if),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fails),
    .pending    (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Abort when nothing moves on any port for too long
  always @(posedge clk) begin
    if (rst || (cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Response side: random stall per word, one long hold on request
  initial begin : rsp_side
    int n;
    rsp_if.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      n = (stall_max > 0) ? $urandom_range(0, stall_max) : 0;
      if (hold_rsp) begin
        hold_rsp = 1'b0;
        n = LONG_HOLD;
      end
      if (n > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_if.valid && rsp_if.ready));
      @(negedge clk);
    end
  end

  // Offer one request word after a random gap and wait for its acceptance
  task automatic send_word(input logic fn, input logic [INDEX_W-1:0] tgt);
    int gap;
    gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_if.valid        <= 1'b1;
    cmd_if.func         <= fn;
    cmd_if.target_index <= tgt;
    do @(posedge clk); while (!(cmd_if.valid && cmd_if.ready));
    @(negedge clk);
  endtask

  // APB write: setup, access, then return to idle
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Drain all outstanding words, then load a full register set
  task automatic reconfigure(input logic [NUM_DIGITS*SIZE_W-1:0] sizes,
                             input logic [15:0] ssel, input logic [31:0] asel,
                             input logic [31:0] tsel, input logic [NUM_DIGITS-1:0] marg);
    cmd_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    reg_write(REG_DIM_SIZES, 32'(sizes));
    reg_write(REG_STATE_SEL, 32'(ssel));
    reg_write(REG_ACTION_SEL, asel);
    reg_write(REG_TYPE_SEL, tsel);
    reg_write(REG_MARG_SEL, 32'(marg));
  endtask

  initial begin : stimulus
    logic [NUM_DIGITS*SIZE_W-1:0] sizes;
    logic [15:0]                  sel [NUM_DIGITS];
    logic [15:0]                  allowed;
    logic [NUM_DIGITS-1:0]        marg;
    int combos;
    int space;
    int eff;
    int fld;
    int r;
    int k;
    int p;
    int tgt;

    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    cmd_if.valid        = 1'b0;
    cmd_if.func         = FN_RESTART;
    cmd_if.target_index = '0;
    gap_max             = 7;
    stall_max           = 7;
    hold_rsp            = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Reset setup: every size counts as one, a single combination
    send_word(FN_RESTART, 20'hFFFFF);
    send_word(FN_SEEK, 20'h00000);
    send_word(FN_SEEK, 20'hFFFFF);

    // Largest sizes, only the top value allowed: all indices at their maximum
    reconfigure(SIZES_ALL_16, 16'h8000, 32'h8000_8000, 32'h8000_8000, 5'b11111);
    send_word(FN_RESTART, 20'h00000);
    send_word(FN_SEEK, 20'hFFFFF);
    send_word(FN_SEEK, 20'h00000);

    // Largest sizes, open masks: forward seek, seek behind, longer seek
    reconfigure(SIZES_ALL_16, 16'h0000, 32'h0, 32'h0, 5'b10101);
    send_word(FN_RESTART, 20'h12345);
    send_word(FN_SEEK, 20'd255);
    send_word(FN_SEEK, 20'd200);
    send_word(FN_SEEK, 20'd1000);

    // Zero and clamped sizes, masks with nothing below the size, empty marginal
    reconfigure({5'd0, 5'd31, 5'd3, 5'd5, 5'd2}, 16'hFFFC, {16'hFFF8, 16'h0015},
                {16'hFFFE, 16'h8001}, 5'b00000);
    send_word(FN_RESTART, 20'h0);
    send_word(FN_SEEK, 20'd40);
    send_word(FN_SEEK, 20'd2000);
    send_word(FN_SEEK, 20'd0);

    // Shrink the sizes under the digits left behind, then restart
    reconfigure(SIZES_ALL_2, 16'h0002, 32'h0, 32'h0, 5'b01010);
    send_word(FN_SEEK, 20'd10);
    send_word(FN_SEEK, 20'd31);
    send_word(FN_SEEK, 20'd5);
    send_word(FN_RESTART, 20'h0);

    // Random phases: bounded walk size, mostly ascending seek targets
    for (p = 0; p < RANDOM_PHASES; p++) begin
      do begin
        combos = 1;
        space  = 1;
        for (k = 0; k < NUM_DIGITS; k++) begin
          r = $urandom_range(0, 9);
          if (r < 6)       fld = $urandom_range(1, 4);
          else if (r == 6) fld = 0;
          else if (r == 7) fld = $urandom_range(17, 31);
          else             fld = $urandom_range(5, 16);
          sizes[SIZE_W*k +: SIZE_W] = SIZE_W'(fld);
          r = $urandom_range(0, 3);
          if (r == 0)      sel[k] = 16'h0;
          else if (r == 1) sel[k] = 16'($urandom & $urandom & $urandom);
          else             sel[k] = 16'($urandom);
          eff     = (fld == 0) ? 1 : (fld > int'(DIM_CAP)) ? int'(DIM_CAP) : fld;
          allowed = sel[k] & 16'((32'd1 << eff) - 1);
          combos  = combos * ((allowed != 16'h0) ? $countones(allowed) : eff);
          space   = space * eff;
        end
      end while (combos > MAX_COMBOS);
      marg = NUM_DIGITS'($urandom_range(0, 31));
      reconfigure(sizes, sel[0], {sel[2], sel[1]}, {sel[4], sel[3]}, marg);

      if (p == 0) hold_rsp = 1'b1;
      gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 7;
      stall_max = ($urandom_range(0, 3) == 0) ? 0 : 7;

      tgt = 0;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          send_word(FN_RESTART, INDEX_W'($urandom));
          tgt = 0;
        end else if (r < 14) begin
          send_word(FN_SEEK, INDEX_W'($urandom));
        end else if (r < 20) begin
          send_word(FN_SEEK, INDEX_W'($urandom_range(0, space - 1)));
        end else begin
          tgt += $urandom_range(0, space / 8 + 1);
          if (tgt >= space) begin
            send_word(FN_RESTART, INDEX_W'($urandom));
            tgt = 0;
          end else begin
            send_word(FN_SEEK, INDEX_W'(tgt));
          end
        end
      end
    end

    // Wait out the last words, then a short quiet period
    cmd_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
